// File: hdl/rbst_pkg.sv
// types and constants for the ray box slab test
// no dependencies
`default_nettype none
package rbst_pkg;
  localparam int unsigned NUM_AXES = 3;

  typedef struct packed {
    logic signed [31:0] origin_x;
    logic signed [31:0] origin_y;
    logic signed [31:0] origin_z;
    logic signed [31:0] dir_x;
    logic signed [31:0] dir_y;
    logic signed [31:0] dir_z;
    logic signed [31:0] box_lo_x;
    logic signed [31:0] box_lo_y;
    logic signed [31:0] box_lo_z;
    logic signed [31:0] box_hi_x;
    logic signed [31:0] box_hi_y;
    logic signed [31:0] box_hi_z;
  } rbst_req_t;

  typedef struct packed {
    logic               hit;
    logic signed [31:0] t_entry;
    logic signed [31:0] t_exit;
  } rbst_res_t;
endpackage
`default_nettype wire

// File: hdl/ray_box_slab_test.sv
// ray versus axis-aligned box slab test, top level
// depends on rbst_pkg, rbst_axis
//
// channel  direction  handshake          payload
// request  in         start_i & !busy_o  req_i (rbst_req_t)
// result   out        done_o strobe      res_o (rbst_res_t)
//
// one request per cycle; one divider stage per quotient bit, 33 + FRAC_BITS
// of them, plus four register stages.
// busy_o is always low: the pipeline never stalls, the receiver cannot
// hold results off. reset clears all valid bits only.
`default_nettype none
module ray_box_slab_test
  import rbst_pkg::*;
#(
  parameter int unsigned FRAC_BITS = 16
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      start_i,
  output logic           busy_o,
  input  wire rbst_req_t req_i,
  output logic           done_o,
  output rbst_res_t      res_o
);
  localparam int unsigned QW = 34 + FRAC_BITS;

  logic signed [31:0] org [NUM_AXES];
  logic signed [31:0] dir [NUM_AXES];
  logic signed [31:0] blo [NUM_AXES];
  logic signed [31:0] bhi [NUM_AXES];
  logic [NUM_AXES-1:0] av, afree, amiss;
  logic signed [QW-1:0] tn [NUM_AXES];
  logic signed [QW-1:0] tf [NUM_AXES];

  assign busy_o = 1'b0;
  assign org = '{req_i.origin_x, req_i.origin_y, req_i.origin_z};
  assign dir = '{req_i.dir_x, req_i.dir_y, req_i.dir_z};
  assign blo = '{req_i.box_lo_x, req_i.box_lo_y, req_i.box_lo_z};
  assign bhi = '{req_i.box_hi_x, req_i.box_hi_y, req_i.box_hi_z};

  for (genvar a = 0; a < NUM_AXES; a++) begin : g_ax
    rbst_axis #(.FRAC_BITS(FRAC_BITS)) u_axis (
      .clk_i, .rst_ni, .valid_i(start_i),
      .origin_i(org[a]), .dir_i(dir[a]), .lo_i(blo[a]), .hi_i(bhi[a]),
      .valid_o(av[a]), .free_o(afree[a]), .miss_o(amiss[a]),
      .tn_o(tn[a]), .tf_o(tf[a])
    );
  end

  // combine stage: max of entries, min of exits, free axes unbounded
  localparam logic signed [QW-1:0] TMAX = {1'b0, {(QW-1){1'b1}}};
  localparam logic signed [QW-1:0] TMIN = {1'b1, {(QW-1){1'b0}}};
  localparam logic signed [QW-1:0] S32MAX = QW'(64'sd2147483647);
  localparam logic signed [QW-1:0] S32MIN = QW'(-64'sd2147483648);

  logic signed [QW-1:0] ent_d, ext_d, ent_q, ext_q;
  logic miss_d, miss_q, c_vld_q;

  always_comb begin
    ent_d  = TMIN;
    ext_d  = TMAX;
    miss_d = |amiss;
    for (int a = 0; a < NUM_AXES; a++) begin
      if (!afree[a]) begin
        if (tn[a] > ent_d) ent_d = tn[a];
        if (tf[a] < ext_d) ext_d = tf[a];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_vld_q <= 1'b0;
      done_o  <= 1'b0;
    end else begin
      c_vld_q <= av[0];
      done_o  <= c_vld_q;
    end
  end

  logic hit_d;
  logic signed [31:0] te_d, tx_d;
  always_comb begin
    hit_d = !miss_q && !ext_q[QW-1] && !(ent_q > ext_q);
    te_d  = (ent_q > S32MAX) ? 32'sh7fffffff :
            (ent_q < S32MIN) ? 32'sh80000000 : ent_q[31:0];
    tx_d  = (ext_q > S32MAX) ? 32'sh7fffffff :
            (ext_q < S32MIN) ? 32'sh80000000 : ext_q[31:0];
  end

  always_ff @(posedge clk_i) begin
    ent_q <= ent_d;
    ext_q <= ext_d;
    miss_q <= miss_d;
    res_o.hit     <= hit_d;
    res_o.t_entry <= hit_d ? te_d : 32'sd0;
    res_o.t_exit  <= hit_d ? tx_d : 32'sd0;
  end

`ifndef SYNTHESIS
  a_axes_aligned: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (av[0] == av[1]) && (av[1] == av[2])) else $error("axis valids apart");
  a_done_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    c_vld_q |=> done_o) else $error("result lost");
  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !res_o.hit) |-> (res_o.t_entry == 0 && res_o.t_exit == 0))
    else $error("miss with distances");
  a_hit_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && res_o.hit) |-> (res_o.t_entry <= res_o.t_exit))
    else $error("entry past exit");
`endif
endmodule
`default_nettype wire

// File: hdl/rbst_div.sv
// pipelined restoring divider, one quotient bit per stage, magnitudes in,
// signed quotient out, sign and a side tag carried along; uses no package
`default_nettype none
module rbst_div #(
  parameter int unsigned NW  = 49,
  parameter int unsigned DW  = 32,
  parameter int unsigned TAGW = 1
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            valid_i,
  input  wire logic [NW-1:0]   num_i,
  input  wire logic [DW-1:0]   den_i,
  input  wire logic            neg_i,
  input  wire logic [TAGW-1:0] tag_i,
  output logic                 valid_o,
  output logic signed [NW:0]   quo_o,
  output logic [TAGW-1:0]      tag_o
);
  // stage s holds remainder, shifted numerator and quotient so far
  logic [NW:0]     vld_q;
  logic [DW:0]     rem_q [NW+1];
  logic [NW-1:0]   num_q [NW+1];
  logic [DW-1:0]   den_q [NW+1];
  logic            neg_q [NW+1];
  logic [TAGW-1:0] tag_q [NW+1];

  always_comb begin
    rem_q[0] = '0;
    num_q[0] = num_i;
    den_q[0] = den_i;
    neg_q[0] = neg_i;
    tag_q[0] = tag_i;
    vld_q[0] = valid_i;
  end

  for (genvar s = 0; s < NW; s++) begin : g_st
    logic [DW+1:0] trial;
    logic [DW:0]   sh;
    logic [DW:0]   rem_d;
    logic [NW-1:0] num_d;
    always_comb begin
      sh    = {rem_q[s][DW-1:0], num_q[s][NW-1]};
      trial = {1'b0, sh} - {2'b00, den_q[s]};
      num_d = {num_q[s][NW-2:0], ~trial[DW+1]};
      rem_d = trial[DW+1] ? sh : trial[DW:0];
    end
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[s+1] <= 1'b0;
      end else begin
        vld_q[s+1] <= vld_q[s];
      end
    end
    always_ff @(posedge clk_i) begin
      rem_q[s+1] <= rem_d;
      num_q[s+1] <= num_d;
      den_q[s+1] <= den_q[s];
      neg_q[s+1] <= neg_q[s];
      tag_q[s+1] <= tag_q[s];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o <= 1'b0;
    end else begin
      valid_o <= vld_q[NW];
    end
  end
  always_ff @(posedge clk_i) begin
    quo_o <= neg_q[NW] ? -$signed({1'b0, num_q[NW]}) : $signed({1'b0, num_q[NW]});
    tag_o <= tag_q[NW];
  end
endmodule
`default_nettype wire

// File: hdl/rbst_axis.sv
// one axis: plane distances, two dividers, ordering of the two parameters
// depends on rbst_div
`default_nettype none
module rbst_axis #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               valid_i,
  input  wire logic signed [31:0] origin_i,
  input  wire logic signed [31:0] dir_i,
  input  wire logic signed [31:0] lo_i,
  input  wire logic signed [31:0] hi_i,
  output logic                    valid_o,
  output logic                    free_o,
  output logic                    miss_o,
  output logic signed [33+FRAC_BITS:0] tn_o,
  output logic signed [33+FRAC_BITS:0] tf_o
);
  localparam int unsigned NW = 33 + FRAC_BITS;

  logic signed [32:0] d_lo, d_hi;
  logic [32:0] m_lo, m_hi;
  logic [31:0] m_dir;
  logic        zero_dir, in_slab;
  logic [1:0]  tag;
  logic        v1, v2;
  logic signed [NW:0] q1, q2;
  logic [1:0]  t1, t2;

  always_comb begin
    d_lo     = 33'(lo_i) - 33'(origin_i);
    d_hi     = 33'(hi_i) - 33'(origin_i);
    m_lo     = d_lo[32] ? 33'(-d_lo) : 33'(d_lo);
    m_hi     = d_hi[32] ? 33'(-d_hi) : 33'(d_hi);
    m_dir    = dir_i[31] ? 32'(-dir_i) : 32'(dir_i);
    zero_dir = (dir_i == '0);
    // origin within slab, corners in either order
    in_slab  = ((origin_i >= lo_i) && (origin_i <= hi_i)) ||
               ((origin_i >= hi_i) && (origin_i <= lo_i));
    tag      = {zero_dir, zero_dir & ~in_slab};
  end

  // zero divisor gives junk quotients that the tag masks off
  rbst_div #(.NW(NW), .DW(32), .TAGW(2)) u_div_lo (
    .clk_i, .rst_ni, .valid_i,
    .num_i({m_lo, {FRAC_BITS{1'b0}}}), .den_i(m_dir),
    .neg_i(d_lo[32] ^ dir_i[31]), .tag_i(tag),
    .valid_o(v1), .quo_o(q1), .tag_o(t1)
  );
  rbst_div #(.NW(NW), .DW(32), .TAGW(2)) u_div_hi (
    .clk_i, .rst_ni, .valid_i,
    .num_i({m_hi, {FRAC_BITS{1'b0}}}), .den_i(m_dir),
    .neg_i(d_hi[32] ^ dir_i[31]), .tag_i(tag),
    .valid_o(v2), .quo_o(q2), .tag_o(t2)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o <= 1'b0;
    end else begin
      valid_o <= v1 & v2;
    end
  end
  always_ff @(posedge clk_i) begin
    free_o <= t1[1];
    miss_o <= t2[0];
    tn_o   <= (q1 < q2) ? q1 : q2;
    tf_o   <= (q1 < q2) ? q2 : q1;
  end
endmodule
`default_nettype wire
